// ===== rtl/efd_pkg.sv =====
// Shared types and constants for the escaped frame deframer.
// Used by efd_ctrl, efd_datapath and escaped_frame_deframer_top; no dependencies.
package efd_pkg;

    localparam int BUFFER_BYTES_DEF = 32;
    localparam int CFG_IDX_W        = 3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FOOTER = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ESCAPE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TYPE_A = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TYPE_B = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_TYPE_C = 3'd5;

    // Reset values of the configuration registers.
    localparam logic [7:0] HEADER_RST = 8'h40;
    localparam logic [7:0] FOOTER_RST = 8'h41;
    localparam logic [7:0] ESCAPE_RST = 8'h42;
    localparam logic [7:0] TYPE_A_RST = 8'h00;
    localparam logic [7:0] TYPE_B_RST = 8'h01;
    localparam logic [7:0] TYPE_C_RST = 8'h02;

    typedef enum logic [2:0] {
        ST_SEARCH,
        ST_READ,
        ST_ESC,
        ST_DRAIN_RD,
        ST_DRAIN_LOAD,
        ST_EMPTY
    } efd_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clear;       // start of a new frame
        logic store;       // store the received byte
        logic store_inv;   // store it inverted (byte after an escape)
        logic rd_start;    // point the read index at the first payload byte
        logic rd_issue;    // read the store at the read index
        logic rd_advance;  // step the read index
        logic load_data;   // load the output register with the read byte
        logic load_empty;  // load the output register with an empty result
    } efd_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_header;
        logic is_footer;
        logic is_escape;
        logic frame_ok;      // frame is deliverable
        logic payload_empty; // frame holds only the type byte
        logic drain_last;    // read index is at the final payload byte
        logic out_free;      // output register can take a result this cycle
    } efd_sts_t;

endpackage

// ===== rtl/efd_ctrl.sv =====
// Controller state machine of the escaped frame deframer.
// Depends on efd_pkg; drives the commands for efd_datapath.
module efd_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  efd_pkg::efd_sts_t sts,
    output efd_pkg::efd_cmd_t cmd
);
    import efd_pkg::*;

    efd_state_t state_reg;
    efd_state_t state_next;
    logic       in_accept;

    assign in_accept = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_SEARCH;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_SEARCH:
            begin
                if (in_accept && sts.is_header)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                if (in_accept)
                begin
                    // Escape takes precedence over footer.
                    if (sts.is_escape)
                    begin
                        state_next = ST_ESC;
                    end
                    else if (sts.is_footer)
                    begin
                        if (!sts.frame_ok)
                        begin
                            state_next = ST_SEARCH;
                        end
                        else if (sts.payload_empty)
                        begin
                            state_next = ST_EMPTY;
                        end
                        else
                        begin
                            state_next = ST_DRAIN_RD;
                        end
                    end
                end
            end
            ST_ESC:
            begin
                if (in_accept)
                begin
                    state_next = ST_READ;
                end
            end
            ST_DRAIN_RD:
            begin
                state_next = ST_DRAIN_LOAD;
            end
            ST_DRAIN_LOAD:
            begin
                if (sts.out_free)
                begin
                    state_next = sts.drain_last ? ST_SEARCH : ST_DRAIN_RD;
                end
            end
            ST_EMPTY:
            begin
                if (sts.out_free)
                begin
                    state_next = ST_SEARCH;
                end
            end
            default:
            begin
                state_next = ST_SEARCH;
            end
        endcase
    end

    // Outputs. In the parsing states in_ready is high, so in_valid alone marks an
    // accepted item.
    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            ST_SEARCH:
            begin
                in_ready  = 1'b1;
                cmd.clear = in_valid && sts.is_header;
            end
            ST_READ:
            begin
                in_ready     = 1'b1;
                cmd.store    = in_valid && !sts.is_escape && !sts.is_footer;
                cmd.rd_start = in_valid && !sts.is_escape && sts.is_footer;
            end
            ST_ESC:
            begin
                in_ready      = 1'b1;
                cmd.store     = in_valid;
                cmd.store_inv = 1'b1;
            end
            ST_DRAIN_RD:
            begin
                cmd.rd_issue = 1'b1;
            end
            ST_DRAIN_LOAD:
            begin
                cmd.load_data  = sts.out_free;
                cmd.rd_advance = sts.out_free && !sts.drain_last;
            end
            ST_EMPTY:
            begin
                cmd.load_empty = sts.out_free;
            end
            default:
            begin
                in_ready = 1'b1;
            end
        endcase
    end

    // No item is taken while a frame is being delivered.
    a_no_input_in_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DRAIN_RD || state_reg == ST_DRAIN_LOAD || state_reg == ST_EMPTY)
        |-> !in_ready)
        else $error("input accepted during frame delivery");

    // A read is always followed by a load attempt in the next cycle.
    a_read_then_load: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rd_issue |=> state_reg == ST_DRAIN_LOAD)
        else $error("store read not followed by output load");

    // A final load returns the parser to header search.
    a_last_to_search: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load_empty || (cmd.load_data && sts.drain_last)) |=> state_reg == ST_SEARCH)
        else $error("frame delivery did not end in header search");

endmodule

// ===== rtl/efd_datapath.sv =====
// Datapath of the escaped frame deframer: configuration registers, frame store,
// fill count, read index and output register. Depends on efd_pkg.
module efd_datapath #(
    parameter int BUFFER_BYTES = efd_pkg::BUFFER_BYTES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    input  logic [efd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]                    cfg_data,
    input  logic [7:0]                    rx_byte,
    input  efd_pkg::efd_cmd_t             cmd,
    output efd_pkg::efd_sts_t             sts,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [7:0]                    msg_type,
    output logic [7:0]                    payload_byte,
    output logic                          byte_valid,
    output logic                          last
);
    import efd_pkg::*;

    localparam int IDXW = $clog2(BUFFER_BYTES);
    localparam int CNTW = $clog2(BUFFER_BYTES + 1);
    localparam logic [CNTW-1:0] FULL_CNT = CNTW'(BUFFER_BYTES);

    logic [7:0] header_reg;
    logic [7:0] footer_reg;
    logic [7:0] escape_reg;
    logic [7:0] type_a_reg;
    logic [7:0] type_b_reg;
    logic [7:0] type_c_reg;

    logic [7:0]      mem [BUFFER_BYTES];
    logic [CNTW-1:0] fill_reg;
    logic            overflowed_reg;
    logic [7:0]      type_reg;
    logic [IDXW-1:0] rd_idx_reg;
    logic [7:0]      rd_data_reg;

    logic            out_valid_reg;
    logic [7:0]      msg_reg;
    logic [7:0]      payload_reg;
    logic            byte_valid_reg;
    logic            last_reg;

    logic            full;
    logic [7:0]      store_data;
    logic            do_write;
    logic            type_match;
    logic            out_load;

    assign full       = (fill_reg == FULL_CNT);
    assign store_data = cmd.store_inv ? ~rx_byte : rx_byte;
    assign do_write   = cmd.store && !full;
    assign type_match = (type_reg == type_a_reg) || (type_reg == type_b_reg)
                     || (type_reg == type_c_reg);
    assign out_load   = cmd.load_data || cmd.load_empty;

    assign sts.is_header     = (rx_byte == header_reg);
    assign sts.is_footer     = (rx_byte == footer_reg);
    assign sts.is_escape     = (rx_byte == escape_reg);
    assign sts.frame_ok      = !overflowed_reg && (fill_reg != '0) && type_match;
    assign sts.payload_empty = (fill_reg == CNTW'(1));
    assign sts.drain_last    = (CNTW'(rd_idx_reg) == (fill_reg - CNTW'(1)));
    assign sts.out_free      = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_reg <= HEADER_RST;
            footer_reg <= FOOTER_RST;
            escape_reg <= ESCAPE_RST;
            type_a_reg <= TYPE_A_RST;
            type_b_reg <= TYPE_B_RST;
            type_c_reg <= TYPE_C_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_HEADER: header_reg <= cfg_data;
                CFG_FOOTER: footer_reg <= cfg_data;
                CFG_ESCAPE: escape_reg <= cfg_data;
                CFG_TYPE_A: type_a_reg <= cfg_data;
                CFG_TYPE_B: type_b_reg <= cfg_data;
                CFG_TYPE_C: type_c_reg <= cfg_data;
                default:    ;
            endcase
        end
    end

    // Frame control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg       <= '0;
            overflowed_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.clear)
            begin
                fill_reg       <= '0;
                overflowed_reg <= 1'b0;
            end
            else if (cmd.store)
            begin
                if (full)
                begin
                    overflowed_reg <= 1'b1;
                end
                else
                begin
                    fill_reg <= fill_reg + CNTW'(1);
                end
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers and the frame store.
    always_ff @(posedge clk)
    begin
        if (do_write)
        begin
            mem[fill_reg[IDXW-1:0]] <= store_data;
        end
        if (cmd.rd_issue)
        begin
            rd_data_reg <= mem[rd_idx_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        // The first stored byte of a frame is its type code.
        if (do_write && (fill_reg == '0))
        begin
            type_reg <= store_data;
        end
        if (cmd.rd_start)
        begin
            rd_idx_reg <= IDXW'(1);
        end
        else if (cmd.rd_advance)
        begin
            rd_idx_reg <= rd_idx_reg + IDXW'(1);
        end
        // The type is copied into the output register so that a waiting result
        // keeps it while the next frame is parsed.
        if (cmd.load_data)
        begin
            msg_reg        <= type_reg;
            payload_reg    <= rd_data_reg;
            byte_valid_reg <= 1'b1;
            last_reg       <= sts.drain_last;
        end
        else if (cmd.load_empty)
        begin
            msg_reg        <= type_reg;
            payload_reg    <= '0;
            byte_valid_reg <= 1'b0;
            last_reg       <= 1'b1;
        end
    end

    assign out_valid    = out_valid_reg;
    assign msg_type     = msg_reg;
    assign payload_byte = payload_reg;
    assign byte_valid   = byte_valid_reg;
    assign last         = last_reg;

    a_fill_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FULL_CNT)
        else $error("fill count beyond store depth");

    a_overflow_full: assert property (@(posedge clk) disable iff (!rst_n)
        overflowed_reg |-> full)
        else $error("overflow flagged while store not full");

    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> sts.out_free)
        else $error("output register overwritten while holding a result");

    a_taken_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_ready && !out_load) |=> !out_valid_reg)
        else $error("taken result still shown");

endmodule

// ===== rtl/escaped_frame_deframer_top.sv =====
// Top level of the escaped frame deframer.
// Depends on efd_pkg, efd_ctrl and efd_datapath.
//
//  channel  | direction | handshake               | payload
//  ---------+-----------+-------------------------+------------------------------------
//  s_axis   | in        | s_axis_tvalid/tready    | tdata[7:0] rx_byte
//  m_axis   | out       | m_axis_tvalid/tready    | tdata msg_type, payload_byte;
//           |           |                         | tuser byte_valid; tlast last
//  cfg      | in        | cfg_valid/cfg_ready     | cfg_index register, cfg_data value
//
// Received bytes are taken one per cycle while a frame is being parsed.
// After an accepted footer, each payload byte takes a registered read of the frame
// store, then the load of the output register, which waits while a held result
// sees m_axis_tready low; no input item is taken until the last result is loaded.
// Reset clears control state only; the frame store needs no clearing pass.
// The output register lets the next frame be parsed while a result waits.
module escaped_frame_deframer_top #(
    parameter int BUFFER_BYTES = efd_pkg::BUFFER_BYTES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [7:0]                    s_axis_tdata,  // [7:0] rx_byte
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [15:0]                   m_axis_tdata,  // [7:0] msg_type, [15:8] payload_byte
    output logic [0:0]                    m_axis_tuser,  // [0] byte_valid
    output logic                          m_axis_tlast,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [efd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]                    cfg_data
);
    import efd_pkg::*;

    efd_cmd_t   cmd;
    efd_sts_t   sts;
    logic [7:0] msg_type;
    logic [7:0] payload_byte;
    logic       byte_valid;

    assign cfg_ready = 1'b1;

    efd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    efd_datapath #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .rx_byte      (s_axis_tdata),
        .cmd          (cmd),
        .sts          (sts),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .msg_type     (msg_type),
        .payload_byte (payload_byte),
        .byte_valid   (byte_valid),
        .last         (m_axis_tlast)
    );

    assign m_axis_tdata = {payload_byte, msg_type};
    assign m_axis_tuser = byte_valid;

endmodule

// ===== verif/escaped_frame_deframer_top_test.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for escaped_frame_deframer_top: drives received bytes and
// register writes, predicts every delivered payload item and checks each one in order.
// Depends on efd_pkg and the deframer RTL.
module escaped_frame_deframer_top_test;
    import efd_pkg::*;

    localparam int STORE_BYTES   = 32;
    localparam int SETTLE_CYCLES = 8;
    localparam int STALL_LIMIT   = 2000;
    localparam int RANDOM_BYTES  = 30;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    typedef enum logic [1:0] {
        HUNT,
        IN_FRAME,
        AFTER_ESC
    } parse_t;

    typedef struct packed {
        logic [7:0] msg_type;
        logic [7:0] payload_byte;
        logic       byte_valid;
        logic       last;
    } payload_item_t;

    typedef logic [7:0] byte_q_t[$];

    logic                 clk           = 1'b0;
    logic                 rst_n         = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [7:0]           s_axis_tdata  = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [15:0]          m_axis_tdata;
    logic [0:0]           m_axis_tuser;
    logic                 m_axis_tlast;
    logic                 cfg_valid     = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index     = '0;
    logic [7:0]           cfg_data      = '0;

    // Predictor copy of the registers and the parser state.
    logic [7:0] hdr_code = HEADER_RST;
    logic [7:0] ftr_code = FOOTER_RST;
    logic [7:0] esc_code = ESCAPE_RST;
    logic [7:0] type_a   = TYPE_A_RST;
    logic [7:0] type_b   = TYPE_B_RST;
    logic [7:0] type_c   = TYPE_C_RST;
    parse_t     parse_st = HUNT;
    int         stored_len = 0;
    logic       store_overrun = 1'b0;
    logic [7:0] frame_bytes[STORE_BYTES];

    payload_item_t expected_items[$];
    int errors       = 0;
    int bytes_sent   = 0;
    int noise_bytes  = 0;
    int sink_stall   = 0;
    int quiet_cycles = 0;
    bit no_idle      = 1'b0;

    escaped_frame_deframer_top #(
        .BUFFER_BYTES(STORE_BYTES)
    ) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .m_axis_tlast (m_axis_tlast),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    task automatic report_error(input string msg);
        $display("%0t: %s", $time, msg);
        errors++;
    endtask

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic keep_byte(input logic [7:0] b);
        if (stored_len < STORE_BYTES)
        begin
            frame_bytes[stored_len] = b;
            stored_len++;
        end
        else
            store_overrun = 1'b1;
    endtask

    // Advances the parser by one received byte and queues the payload items it delivers.
    task automatic deframe_byte(input logic [7:0] b);
        payload_item_t it;
        logic [7:0]    kind;
        case (parse_st)
            IN_FRAME:
            begin
                // The escape test comes first, so it wins over an equal footer code.
                if (b == esc_code)
                    parse_st = AFTER_ESC;
                else if (b == ftr_code)
                begin
                    parse_st = HUNT;
                    if (!store_overrun && stored_len != 0)
                    begin
                        kind = frame_bytes[0];
                        if (kind == type_a || kind == type_b || kind == type_c)
                        begin
                            if (stored_len == 1)
                            begin
                                it = '{kind, 8'h00, 1'b0, 1'b1};
                                expected_items.push_back(it);
                            end
                            else
                            begin
                                for (int i = 1; i < stored_len; i++)
                                begin
                                    it = '{kind, frame_bytes[i], 1'b1,
                                           logic'(i == stored_len - 1)};
                                    expected_items.push_back(it);
                                end
                            end
                        end
                    end
                end
                else
                    keep_byte(b);
            end
            AFTER_ESC:
            begin
                keep_byte(~b);
                parse_st = IN_FRAME;
            end
            default:
            begin
                if (b == hdr_code)
                begin
                    stored_len    = 0;
                    store_overrun = 1'b0;
                    parse_st      = IN_FRAME;
                end
            end
        endcase
    endtask

    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        do
            @(posedge clk);
        while (!s_axis_tready);
        deframe_byte(b);
        bytes_sent++;
    endtask

    // Sends header, stuffed content and footer with the current codes. Bytes that
    // collide with the escape or footer code are escaped, a few others at random too.
    task automatic send_frame(input byte_q_t content);
        send_byte(hdr_code);
        foreach (content[i])
        begin
            if (content[i] == esc_code || content[i] == ftr_code || $urandom_range(0, 9) == 0)
            begin
                send_byte(esc_code);
                send_byte(~content[i]);
            end
            else
                send_byte(content[i]);
        end
        send_byte(ftr_code);
    endtask

    // Holds the sender until every expected item has come and the block has settled.
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (expected_items.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Writes every register; the two spare indexes are written too and must be ignored.
    task automatic set_codes(input logic [7:0] h, input logic [7:0] f, input logic [7:0] e,
                             input logic [7:0] a, input logic [7:0] b, input logic [7:0] c);
        logic [CFG_IDX_W-1:0] idx[8];
        logic [7:0]           val[8];
        idx = '{CFG_SPARE_LO, CFG_SPARE_HI, CFG_HEADER, CFG_FOOTER,
                CFG_ESCAPE, CFG_TYPE_A, CFG_TYPE_B, CFG_TYPE_C};
        val = '{8'($urandom), 8'($urandom), h, f, e, a, b, c};
        wait_idle();
        for (int k = 0; k < 8; k++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[k];
            cfg_data  <= val[k];
            do
                @(posedge clk);
            while (!cfg_ready);
            case (idx[k])
                CFG_HEADER: hdr_code = val[k];
                CFG_FOOTER: ftr_code = val[k];
                CFG_ESCAPE: esc_code = val[k];
                CFG_TYPE_A: type_a   = val[k];
                CFG_TYPE_B: type_b   = val[k];
                CFG_TYPE_C: type_c   = val[k];
                default: ;
            endcase
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic test_basic_frames();
        send_byte(8'h13);
        send_frame('{TYPE_A_RST, 8'h00, 8'hFF});
        send_frame('{TYPE_C_RST});
        send_byte(HEADER_RST);
        send_byte(FOOTER_RST);
        send_frame('{8'h03, 8'h55});
        send_frame('{TYPE_B_RST, HEADER_RST, FOOTER_RST, ESCAPE_RST});
        // An escaped header byte is stored inverted like any other.
        send_byte(HEADER_RST);
        send_byte(TYPE_A_RST);
        send_byte(ESCAPE_RST);
        send_byte(HEADER_RST);
        send_byte(FOOTER_RST);
    endtask

    task automatic test_store_limit();
        byte_q_t content;
        content.push_back(type_a);
        repeat (STORE_BYTES - 1) content.push_back(8'($urandom));
        send_frame(content);
        // One byte more than the store holds: the whole frame is dropped.
        content.push_back(8'($urandom));
        send_frame(content);
        send_frame('{type_b, 8'hA5});
    endtask

    task automatic test_code_extremes();
        set_codes(8'h00, 8'hFF, 8'h80, 8'hFF, 8'h7F, 8'h00);
        send_frame('{8'hFF, 8'h00, 8'hFF, 8'h80});
        send_frame('{8'h7F});
        send_frame('{8'h00, 8'h01});
        set_codes(8'hFF, 8'h00, 8'h7F, 8'h80, 8'h01, 8'hFE);
        send_frame('{8'h80, 8'hFF, 8'h00});
        send_frame('{8'hFE, 8'h7F});
    endtask

    task automatic test_equal_codes();
        // Header equal to footer: inside a frame the byte ends it.
        set_codes(8'h10, 8'h10, 8'h20, 8'h00, 8'h01, 8'h02);
        send_byte(8'h10);
        send_byte(8'h01);
        send_byte(8'h33);
        send_byte(8'h10);
        // Footer equal to escape: the frame cannot end until the footer is moved.
        set_codes(8'h30, 8'h31, 8'h31, 8'h00, 8'h01, 8'h02);
        send_byte(8'h30);
        send_byte(8'h00);
        send_byte(8'h31);
        send_byte(8'h31);
        set_codes(8'h30, 8'h32, 8'h31, 8'h00, 8'h01, 8'h02);
        send_byte(8'h32);
        // Header equal to escape: inside a frame it escapes.
        set_codes(8'h50, 8'h51, 8'h50, 8'h00, 8'h01, 8'h02);
        send_byte(8'h50);
        send_byte(8'h02);
        send_byte(8'h50);
        send_byte(8'h51);
        send_byte(8'h51);
    endtask

    task automatic random_frame();
        byte_q_t    content;
        int         len;
        int         r;
        logic [7:0] kind;
        case ($urandom_range(0, 4))
            0: kind = type_a;
            1: kind = type_b;
            2: kind = type_c;
            3: kind = 8'($urandom);
            default: kind = type_a;
        endcase
        r = $urandom_range(0, 99);
        if (r < 80)
            len = $urandom_range(0, 6);
        else if (r < 94)
            len = $urandom_range(7, STORE_BYTES - 1);
        else
            len = $urandom_range(STORE_BYTES, STORE_BYTES + 2);
        content.push_back(kind);
        repeat (len) content.push_back(8'($urandom));
        r = $urandom_range(0, 99);
        if (r < 10)
        begin
            repeat ($urandom_range(1, 4))
            begin
                send_byte(8'($urandom));
                noise_bytes++;
            end
            send_frame(content);
        end
        else if (r < 18)
        begin
            // Broken frame: raw content, no footer, sometimes a dangling escape.
            send_byte(hdr_code);
            foreach (content[i])
                send_byte(content[i]);
            if ($urandom_range(0, 1) == 1)
                send_byte(esc_code);
        end
        else
            send_frame(content);
    endtask

    task automatic test_random_traffic();
        int         first;
        logic [7:0] h;
        logic [7:0] f;
        logic [7:0] e;
        set_codes(HEADER_RST, FOOTER_RST, ESCAPE_RST, TYPE_A_RST, TYPE_B_RST, TYPE_C_RST);
        first       = bytes_sent;
        noise_bytes = 0;
        while (bytes_sent - first - noise_bytes < RANDOM_BYTES)
        begin
            if ($urandom_range(0, 7) == 0)
            begin
                do
                begin
                    h = 8'($urandom);
                    f = 8'($urandom);
                    e = 8'($urandom);
                end
                while (h == f || h == e || f == e);
                set_codes(h, f, e, 8'($urandom), 8'($urandom), 8'($urandom));
            end
            no_idle = ($urandom_range(0, 4) == 0);
            random_frame();
            if ($urandom_range(0, 5) == 0)
                wait_idle();
        end
        no_idle = 1'b0;
    endtask

    // Result sink: checks each accepted item against the oldest expectation.
    always @(posedge clk)
    begin : sink
        payload_item_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_items.size() == 0)
                report_error($sformatf("unexpected item type %02h byte %02h",
                                       m_axis_tdata[7:0], m_axis_tdata[15:8]));
            else
            begin
                want = expected_items.pop_front();
                if (m_axis_tdata[7:0] !== want.msg_type)
                    report_error($sformatf("msg_type got %02h want %02h",
                                           m_axis_tdata[7:0], want.msg_type));
                if (m_axis_tdata[15:8] !== want.payload_byte)
                    report_error($sformatf("payload_byte got %02h want %02h",
                                           m_axis_tdata[15:8], want.payload_byte));
                if (m_axis_tuser[0] !== want.byte_valid)
                    report_error($sformatf("byte_valid got %b want %b",
                                           m_axis_tuser[0], want.byte_valid));
                if (m_axis_tlast !== want.last)
                    report_error($sformatf("last got %b want %b", m_axis_tlast, want.last));
            end
        end
        if (sink_stall > 0)
        begin
            m_axis_tready <= 1'b0;
            sink_stall--;
        end
        else
        begin
            m_axis_tready <= 1'b1;
            if ($urandom_range(0, 3) == 0)
                sink_stall = pick_gap();
        end
    end

    // Ends the run if no handshake happens on any channel for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                (cfg_valid && cfg_ready))
                quiet_cycles <= 0;
            else if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("escaped_frame_deframer_top test failed");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_basic_frames();
        test_store_limit();
        test_code_extremes();
        test_equal_codes();
        test_random_traffic();
        wait_idle();
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("escaped_frame_deframer_top test passed");
        else
            $display("escaped_frame_deframer_top test failed");
        $finish;
    end

endmodule
